/* hdl/wheel_odometry_encoder_emulator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the wheel odometry encoder emulator.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ODOMETRY_ENCODER_EMULATOR_MACROS_SVH
`define WHEEL_ODOMETRY_ENCODER_EMULATOR_MACROS_SVH

// Same-cycle implication
`define WOE_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("woe assertion failed");

// Next-cycle implication
`define WOE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("woe assertion failed");

`endif

/* hdl/woe_pkg.sv */
// ----------------------------------------------------------------------------
// woe_pkg
// Types, fixed-point constants and widths shared by the odometry emulator.
// ----------------------------------------------------------------------------
package woe_pkg;

  // Angle and count formats
  localparam int ANGLE_BITS      = 16;
  localparam int COUNT_FRAC_BITS = 16;
  localparam int ANG_FRAC        = ANGLE_BITS - 3;
  localparam int SPEED_W         = 16;
  localparam int LIM_W           = 15;
  localparam int RES_W           = 10;
  localparam int GEAR_W          = 12;
  localparam int COUNT_W         = 32;
  localparam int ACC_W           = COUNT_W + COUNT_FRAC_BITS;

  // pi in Q(ANG_FRAC), rounded from a Q30 value
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int PI_FX      = int'(((PI_Q30 >> (29 - ANG_FRAC)) + 64'd1) >> 1);
  localparam int TWO_PI_FX  = 2 * PI_FX;
  localparam int FOUR_PI_FX = 4 * PI_FX;
  localparam int HALF_DV    = FOUR_PI_FX / 2;
  localparam int DV_W       = $clog2(FOUR_PI_FX + 1);

  // Datapath widths of one side lane
  localparam int DELTA_W = ANGLE_BITS + 1;
  localparam int SUM_W   = ANGLE_BITS + 2;
  localparam int MAG_W   = ANGLE_BITS + 1;
  localparam int P1_W    = MAG_W + RES_W;
  localparam int P2_W    = P1_W + GEAR_W;
  localparam int NUM_W   = P2_W + COUNT_FRAC_BITS + 1;

  // Constant divider: RADIX_BITS quotient bits per cycle
  localparam int RADIX_BITS  = 4;
  localparam int DIV_ITERS   = (NUM_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DIV_W       = DIV_ITERS * RADIX_BITS;
  localparam int ITER_CNT_W  = $clog2(DIV_ITERS);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RES       = 2'd0,
    CFG_GEAR      = 2'd1,
    CFG_MAX_SPEED = 2'd2
  } cfg_idx_e;

  // Input beat
  typedef struct packed {
    logic                          clear_counts;
    logic signed [SPEED_W-1:0]     right_speed_cmd;
    logic signed [SPEED_W-1:0]     left_speed_cmd;
    logic signed [ANGLE_BITS-1:0]  front_right_angle;
    logic signed [ANGLE_BITS-1:0]  rear_right_angle;
    logic signed [ANGLE_BITS-1:0]  front_left_angle;
    logic signed [ANGLE_BITS-1:0]  rear_left_angle;
    logic signed [ANGLE_BITS-1:0]  right_rocker_angle;
    logic signed [ANGLE_BITS-1:0]  left_rocker_angle;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic signed [SPEED_W-1:0]     right_drive;
    logic signed [SPEED_W-1:0]     left_drive;
    logic signed [COUNT_W-1:0]     right_count;
    logic signed [COUNT_W-1:0]     left_count;
    logic signed [ANGLE_BITS-1:0]  balance_target;
    logic                          wheels_active;
  } out_item_t;

  // Control into a side lane
  typedef struct packed {
    logic start;
    logic clear;
    logic ack;
  } lane_ctl_t;

  // Status out of a side lane
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } lane_stat_t;

endpackage

/* hdl/wheel_odometry_encoder_emulator.sv */
// ----------------------------------------------------------------------------
// wheel_odometry_encoder_emulator
// Encoder count emulation for a four-wheel, two-rocker rover.
// ----------------------------------------------------------------------------
// One beat is worked at a time. A normal beat goes from acceptance to a
// valid result through these steps: a registered start, two multiply
// steps, a load, the radix-16 divider by 4*pi in each side lane, an
// accumulate and a handoff to the output register. A beat with
// clear_counts set skips the arithmetic.
// The two side lanes run in parallel, so the divider loop sets the rate.
// A new beat is taken as soon as the result moves to the output register,
// even while that result still waits for out_ready_i. Configuration writes
// are always accepted; write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "wheel_odometry_encoder_emulator_macros.svh"

module wheel_odometry_encoder_emulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [woe_pkg::LIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  woe_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output woe_pkg::out_item_t            out_data_o
);

  logic [woe_pkg::RES_W-1:0]   res_q;
  logic [woe_pkg::GEAR_W-1:0]  gear_q;
  logic [woe_pkg::LIM_W-1:0]   max_speed_q;
  logic                        busy_q;
  logic                        start_q;
  woe_pkg::in_item_t           hold_q;
  logic                        load;
  woe_pkg::lane_ctl_t          lane_ctl;
  woe_pkg::lane_stat_t         lane_r_stat, lane_l_stat;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= woe_pkg::RES_W'(16);
      gear_q      <= woe_pkg::GEAR_W'(192);
      max_speed_q <= woe_pkg::LIM_W'(5120);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        woe_pkg::CFG_RES:       res_q       <= cfg_data_i[woe_pkg::RES_W-1:0];
        woe_pkg::CFG_GEAR:      gear_q      <= cfg_data_i[woe_pkg::GEAR_W-1:0];
        woe_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input beat capture and busy tracking
  assign in_ready_o = ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      start_q <= 1'b0;
    end else begin
      start_q <= in_valid_i & ~busy_q;
      if (in_valid_i && !busy_q) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !busy_q) begin
      hold_q <= in_data_i;
    end
  end

  assign lane_ctl.start = start_q;
  assign lane_ctl.clear = hold_q.clear_counts;
  assign lane_ctl.ack   = load;

  // Side lanes
  woe_lane u_lane_r (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (lane_ctl),
    .front_angle_i (hold_q.front_right_angle),
    .rear_angle_i  (hold_q.rear_right_angle),
    .res_i         (res_q),
    .gear_i        (gear_q),
    .stat_o        (lane_r_stat)
  );

  woe_lane u_lane_l (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (lane_ctl),
    .front_angle_i (hold_q.front_left_angle),
    .rear_angle_i  (hold_q.rear_left_angle),
    .res_i         (res_q),
    .gear_i        (gear_q),
    .stat_o        (lane_l_stat)
  );

  // Merge and output register
  woe_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (hold_q),
    .right_i     (lane_r_stat),
    .left_i      (lane_l_stat),
    .max_speed_i (max_speed_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .load_o      (load)
  );

  // Assertions
  `WOE_ASSERT(a_lanes_in_step, 1'b1, lane_r_stat.done == lane_l_stat.done)
  `WOE_ASSERT(a_done_while_busy, lane_r_stat.done, busy_q)
  `WOE_ASSERT_NEXT(a_clear_zeroes, load && hold_q.clear_counts, out_data_o.right_count == '0 && out_data_o.left_count == '0)

endmodule

/* hdl/woe_lane.sv */
// ----------------------------------------------------------------------------
// woe_lane
// One side of the rover: wraps two wheel deltas, scales their sum into
// encoder counts through two multiplies and a radix-16 constant divider,
// and keeps the wrapping fixed-point count.
// ----------------------------------------------------------------------------
module woe_lane (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  woe_pkg::lane_ctl_t                       ctl_i,
  input  logic signed [woe_pkg::ANGLE_BITS-1:0]    front_angle_i,
  input  logic signed [woe_pkg::ANGLE_BITS-1:0]    rear_angle_i,
  input  logic [woe_pkg::RES_W-1:0]                res_i,
  input  logic [woe_pkg::GEAR_W-1:0]               gear_i,
  output woe_pkg::lane_stat_t                      stat_o
);

  localparam int AB   = woe_pkg::ANGLE_BITS;
  localparam int DW   = woe_pkg::DELTA_W;
  localparam int SW   = woe_pkg::SUM_W;
  localparam int MW   = woe_pkg::MAG_W;
  localparam int RW   = woe_pkg::RES_W;
  localparam int GW   = woe_pkg::GEAR_W;
  localparam int P1W  = woe_pkg::P1_W;
  localparam int P2W  = woe_pkg::P2_W;
  localparam int DIVW = woe_pkg::DIV_W;
  localparam int DVW  = woe_pkg::DV_W;
  localparam int ACW  = woe_pkg::ACC_W;
  localparam int FB   = woe_pkg::COUNT_FRAC_BITS;
  localparam int ICW  = woe_pkg::ITER_CNT_W;

  localparam logic signed [DW-1:0] PI_S     = DW'(woe_pkg::PI_FX);
  localparam logic signed [DW-1:0] TWO_PI_S = DW'(woe_pkg::TWO_PI_FX);
  localparam logic [DVW:0]         DV_EXT   = (DVW + 1)'(woe_pkg::FOUR_PI_FX);
  localparam logic [DIVW-1:0]      HALF_EXT = DIVW'(woe_pkg::HALF_DV);
  localparam logic [ICW-1:0]       ITER_LAST = ICW'(woe_pkg::DIV_ITERS - 1);

  typedef enum logic [6:0] {
    L_IDLE = 7'b0000001,
    L_MUL1 = 7'b0000010,
    L_MUL2 = 7'b0000100,
    L_LOAD = 7'b0001000,
    L_DIV  = 7'b0010000,
    L_ACC  = 7'b0100000,
    L_DONE = 7'b1000000
  } lane_state_e;

  lane_state_e             state_q;
  logic signed [AB-1:0]    prev_front_q, prev_rear_q;
  logic [ACW-1:0]          acc_q;
  logic [MW-1:0]           mag_q;
  logic                    neg_q;
  logic [P1W-1:0]          prod1_q;
  logic [P2W-1:0]          prod2_q;
  logic [DIVW-1:0]         num_q;
  logic [DVW-1:0]          rem_q;
  logic [ICW-1:0]          iter_q;

  logic signed [DW-1:0]    d_front, d_rear;
  logic signed [SW-1:0]    sum_w;
  logic [SW-1:0]           abs_w;
  logic [DIVW-1:0]         num_d;
  logic [DVW-1:0]          rem_d;

  // Angle change, wrapped once by 2*pi
  function automatic logic signed [DW-1:0] wrap_delta(
    input logic signed [AB-1:0] cur,
    input logic signed [AB-1:0] prev
  );
    logic signed [DW-1:0] d;
    d = {cur[AB-1], cur} - {prev[AB-1], prev};
    if (d < -PI_S) begin
      d = d + TWO_PI_S;
    end else if (d > PI_S) begin
      d = d - TWO_PI_S;
    end
    return d;
  endfunction

  // Side sum and its magnitude
  always_comb begin
    d_front = wrap_delta(front_angle_i, prev_front_q);
    d_rear  = wrap_delta(rear_angle_i, prev_rear_q);
    sum_w   = {d_front[DW-1], d_front} + {d_rear[DW-1], d_rear};
    abs_w   = sum_w[SW-1] ? (~sum_w + 1'b1) : sum_w;
  end

  // Restoring division by 4*pi, RADIX_BITS quotient bits per cycle
  always_comb begin
    logic [DVW:0] trial;
    logic         qbit;
    rem_d = rem_q;
    num_d = num_q;
    for (int k = 0; k < woe_pkg::RADIX_BITS; k++) begin
      trial = {rem_d, num_d[DIVW-1]};
      qbit  = (trial >= DV_EXT);
      if (qbit) begin
        rem_d = DVW'(trial - DV_EXT);
      end else begin
        rem_d = trial[DVW-1:0];
      end
      num_d = {num_d[DIVW-2:0], qbit};
    end
  end

  // Sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= L_IDLE;
      prev_front_q <= '0;
      prev_rear_q  <= '0;
      acc_q        <= '0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (ctl_i.start) begin
            if (ctl_i.clear) begin
              prev_front_q <= '0;
              prev_rear_q  <= '0;
              acc_q        <= '0;
              state_q      <= L_DONE;
            end else begin
              prev_front_q <= front_angle_i;
              prev_rear_q  <= rear_angle_i;
              state_q      <= L_MUL1;
            end
          end
        end
        L_MUL1:  state_q <= L_MUL2;
        L_MUL2:  state_q <= L_LOAD;
        L_LOAD:  state_q <= L_DIV;
        L_DIV: begin
          if (iter_q == ITER_LAST) begin
            state_q <= L_ACC;
          end
        end
        L_ACC: begin
          // quotient is the rounded increment
          if (neg_q) begin
            acc_q <= acc_q - num_q[ACW-1:0];
          end else begin
            acc_q <= acc_q + num_q[ACW-1:0];
          end
          state_q <= L_DONE;
        end
        L_DONE: begin
          if (ctl_i.ack) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        mag_q <= abs_w[MW-1:0];
        neg_q <= sum_w[SW-1];
      end
      L_MUL1: prod1_q <= {{RW{1'b0}}, mag_q} * {{MW{1'b0}}, res_i};
      L_MUL2: prod2_q <= {{GW{1'b0}}, prod1_q} * {{P1W{1'b0}}, gear_i};
      L_LOAD: begin
        num_q  <= DIVW'({prod2_q, {FB{1'b0}}}) + HALF_EXT;
        rem_q  <= '0;
        iter_q <= '0;
      end
      L_DIV: begin
        num_q  <= num_d;
        rem_q  <= rem_d;
        iter_q <= iter_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign stat_o.done  = (state_q == L_DONE);
  assign stat_o.count = acc_q[ACW-1:FB];

endmodule

/* hdl/woe_merge.sv */
// ----------------------------------------------------------------------------
// woe_merge
// Joins the two side lanes with the speed clamp and rocker balance and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module woe_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  woe_pkg::in_item_t               item_i,
  input  woe_pkg::lane_stat_t             right_i,
  input  woe_pkg::lane_stat_t             left_i,
  input  logic [woe_pkg::LIM_W-1:0]       max_speed_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output woe_pkg::out_item_t              out_data_o,
  output logic                            load_o
);

  localparam int SPW = woe_pkg::SPEED_W;
  localparam int AB  = woe_pkg::ANGLE_BITS;

  logic                   out_valid_q;
  woe_pkg::out_item_t     out_q;
  logic signed [SPW-1:0]  rd, ld;
  logic signed [AB:0]     rock_diff;

  // Clamp a speed to +/- limit
  function automatic logic signed [SPW-1:0] clamp(
    input logic signed [SPW-1:0]     s,
    input logic [woe_pkg::LIM_W-1:0] lim
  );
    logic signed [SPW-1:0] hi;
    logic signed [SPW-1:0] lo;
    hi = signed'({1'b0, lim});
    lo = -hi;
    if (s > hi) begin
      return hi;
    end else if (s < lo) begin
      return lo;
    end
    return s;
  endfunction

  always_comb begin
    rd        = clamp(item_i.right_speed_cmd, max_speed_i);
    ld        = clamp(item_i.left_speed_cmd, max_speed_i);
    rock_diff = {item_i.right_rocker_angle[AB-1], item_i.right_rocker_angle}
              - {item_i.left_rocker_angle[AB-1], item_i.left_rocker_angle};
  end

  // Take both lanes once the output register is free
  assign load_o = right_i.done & left_i.done & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      out_q.right_drive    <= rd;
      out_q.left_drive     <= ld;
      out_q.right_count    <= right_i.count;
      out_q.left_count     <= left_i.count;
      // arithmetic half, floors odd differences
      out_q.balance_target <= rock_diff[AB:1];
      out_q.wheels_active  <= (rd != '0) | (ld != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
